FILE: rtl/core/ssmh_pkg.sv
// shared types and constants for the spectral soft mask history core
package ssmh_pkg;

    localparam int WeightW = 17;
    localparam int MaskW = 16;
    localparam longint unsigned PiQ30 = 64'd3373259426;

    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } t_acc_ctl;

endpackage

FILE: rtl/core/spectral_soft_mask_history_core.sv
// spectral soft mask history core: per-bin history ring in memory, weighted power ratio
//
// channel  | direction | contents
// s_axis   | in        | tdata mixture re/im, source re/im; tlast last bin
// m_axis   | out       | tdata mask, centered mix/src; tuser mask valid; tlast frame end
// cfg      | in        | processing enable
//
// one item at a time; an item takes a single history write (HISTORY_DEPTH writes in the
// first frame), HISTORY_DEPTH memory reads, the accumulate pipeline, the bit-serial divider
// and the output handoff; writes and reads share the single memory port.
// the next item is taken while a result waits on m_axis.
// reset is synchronous; history memory holds no reset value and needs no clearing.
module spectral_soft_mask_history_core
    import ssmh_pkg::*;
#(
    parameter int HISTORY_DEPTH = 8,
    parameter int NUM_BINS = 1024,
    parameter int SAMPLE_BITS = 24
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // mixture_re, mixture_im, source_re, source_im
    input  logic [((4*SAMPLE_BITS+7)/8)*8-1:0] s_axis_tdata,
    input  logic s_axis_tlast,
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    // mask, centered_mix_re, centered_mix_im, centered_src_re, centered_src_im
    output logic [((4*SAMPLE_BITS+16+7)/8)*8-1:0] m_axis_tdata,
    // mask_valid
    output logic m_axis_tuser,
    output logic m_axis_tlast,
    input  logic i_cfg_valid,
    output logic o_cfg_ready,
    input  logic i_cfg_data
);

    localparam int SB = SAMPLE_BITS;
    localparam int RW = SB + 1;
    localparam int MW = 2 * RW + 2 * SB;
    localparam int DEPTH = NUM_BINS * HISTORY_DEPTH;
    localparam int AD = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SLW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int PBW = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
    localparam int AW = 2 * RW + 1 + WeightW + SLW + 1;
    localparam int MID = HISTORY_DEPTH / 2;
    localparam int OUT_TW = ((4 * SB + 16 + 7) / 8) * 8;
    localparam longint unsigned NDIV = (HISTORY_DEPTH > 1) ? HISTORY_DEPTH - 1 : 1;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_WRITE = 3'd1;
    localparam logic [2:0] ST_READ  = 3'd2;
    localparam logic [2:0] ST_ACC   = 3'd3;
    localparam logic [2:0] ST_DIV   = 3'd4;
    localparam logic [2:0] ST_OUT   = 3'd5;

    // hanning weight table
    logic [WeightW-1:0] w_weight [HISTORY_DEPTH];

    for (genvar j = 0; j < HISTORY_DEPTH; j++) begin : g_weight
        localparam longint unsigned KJ = (2 * j > NDIV) ? NDIV - j : j;
        localparam longint unsigned X  = (PiQ30 * KJ) / NDIV;
        localparam longint unsigned X2 = (X * X) >> 30;
        localparam longint unsigned T1 = ((X * X2) >> 30) / 6;
        localparam longint unsigned T2 = ((T1 * X2) >> 30) / 20;
        localparam longint unsigned T3 = ((T2 * X2) >> 30) / 42;
        localparam longint unsigned T4 = ((T3 * X2) >> 30) / 72;
        localparam longint unsigned T5 = ((T4 * X2) >> 30) / 110;
        localparam longint SUMS = longint'(X) - longint'(T1) + longint'(T2)
                                  - longint'(T3) + longint'(T4) - longint'(T5);
        localparam longint unsigned S = (SUMS < 0) ? 0 : longint'(SUMS);
        localparam longint unsigned WR = (S * S + (64'd1 << 43)) >> 44;
        localparam longint unsigned WV = (HISTORY_DEPTH <= 1) ? 65536
                                         : ((WR > 65536) ? 65536 : WR);
        assign w_weight[j] = WeightW'(WV);
    end

    function automatic logic [SLW-1:0] slot_inc(input logic [SLW-1:0] s);
        return (s == SLW'(HISTORY_DEPTH - 1)) ? '0 : s + SLW'(1);
    endfunction

    logic [2:0]      r_state;
    logic            r_enable;
    logic [SLW-1:0]  r_newest;
    logic            r_primed;
    logic [PBW-1:0]  r_pos;

    logic [AD-1:0]   r_base;
    logic [MW-1:0]   r_wdata;
    logic            r_ends;
    logic [SLW-1:0]  r_wslot, r_rslot, r_age;

    logic [MW-1:0]   r_mem [DEPTH];
    logic [MW-1:0]   r_rdata;
    logic [AD-1:0]   w_addr;
    logic            w_wr;
    logic            r_rd_valid, r_rd_first, r_rd_last;
    logic [SLW-1:0]  r_rd_age;

    logic signed [SB-1:0] w_mix_re, w_mix_im, w_src_re, w_src_im;
    logic signed [RW-1:0] w_res_re, w_res_im;
    logic signed [SB-1:0] w_rd_sre, w_rd_sim;
    logic signed [RW-1:0] w_rd_rre, w_rd_rim;
    logic [SB-1:0]   r_cmix_re, r_cmix_im, r_csrc_re, r_csrc_im;

    t_acc_ctl        w_acc_ctl;
    logic [AW-1:0]   w_ssum, w_tsum;
    logic            w_acc_done, w_div_start, w_div_done;
    logic [MaskW-1:0] w_q;
    logic [MaskW-1:0] r_mask;

    logic            r_out_valid, r_out_last, r_out_user;
    logic [MaskW-1:0] r_out_mask;
    logic [SB-1:0]   r_out_cmre, r_out_cmim, r_out_csre, r_out_csim;
    logic            w_accept, w_load;

    assign w_mix_re = s_axis_tdata[SB-1:0];
    assign w_mix_im = s_axis_tdata[2*SB-1:SB];
    assign w_src_re = s_axis_tdata[3*SB-1:2*SB];
    assign w_src_im = s_axis_tdata[4*SB-1:3*SB];
    assign w_res_re = RW'(w_mix_re) - RW'(w_src_re);
    assign w_res_im = RW'(w_mix_im) - RW'(w_src_im);

    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_accept = s_axis_tvalid & s_axis_tready;
    assign o_cfg_ready = 1'b1;
    assign w_load = (r_state == ST_OUT) & (~r_out_valid | m_axis_tready);

    // history memory
    assign w_wr = (r_state == ST_WRITE);
    assign w_addr = r_base + AD'((r_state == ST_WRITE) ? r_wslot : r_rslot);

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[w_addr] <= r_wdata;
        end
        r_rdata <= r_mem[w_addr];
    end

    assign w_rd_rre = r_rdata[RW-1:0];
    assign w_rd_rim = r_rdata[2*RW-1:RW];
    assign w_rd_sre = r_rdata[2*RW+SB-1:2*RW];
    assign w_rd_sim = r_rdata[MW-1:2*RW+SB];

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_base  <= AD'(r_pos * HISTORY_DEPTH);
            r_wdata <= {w_src_im, w_src_re, w_res_im, w_res_re};
            r_ends  <= s_axis_tlast | (r_pos == PBW'(NUM_BINS - 1));
            r_wslot <= r_primed ? slot_inc(r_newest) : '0;
            r_rslot <= r_primed ? slot_inc(slot_inc(r_newest)) : slot_inc(r_newest);
            r_age   <= '0;
        end else if (r_state == ST_WRITE) begin
            r_wslot <= slot_inc(r_wslot);
        end else if (r_state == ST_READ) begin
            r_rslot <= slot_inc(r_rslot);
            r_age   <= r_age + SLW'(1);
        end
        r_rd_age   <= r_age;
        r_rd_first <= (r_age == '0);
        r_rd_last  <= (r_age == SLW'(HISTORY_DEPTH - 1));
        if (r_rd_valid && r_rd_age == SLW'(MID)) begin
            r_cmix_re <= SB'(w_rd_rre + RW'(w_rd_sre));
            r_cmix_im <= SB'(w_rd_rim + RW'(w_rd_sim));
            r_csrc_re <= w_rd_sre;
            r_csrc_im <= w_rd_sim;
        end
        if (w_div_done) begin
            r_mask <= w_q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_enable   <= 1'b1;
            r_newest   <= '0;
            r_primed   <= 1'b0;
            r_pos      <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            r_rd_valid <= (r_state == ST_READ);
            if (i_cfg_valid) begin
                r_enable <= i_cfg_data;
            end
            case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_state <= ST_WRITE;
                    end
                end
                ST_WRITE: begin
                    if (r_primed || r_wslot == SLW'(HISTORY_DEPTH - 1)) begin
                        r_state <= ST_READ;
                    end
                end
                ST_READ: begin
                    if (r_age == SLW'(HISTORY_DEPTH - 1)) begin
                        r_state <= ST_ACC;
                    end
                end
                ST_ACC: begin
                    if (w_acc_done) begin
                        r_state <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (w_div_done) begin
                        r_state <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (w_load) begin
                        r_state <= ST_IDLE;
                        if (r_ends) begin
                            if (r_primed) begin
                                r_newest <= slot_inc(r_newest);
                            end
                            r_primed <= 1'b1;
                            r_pos    <= '0;
                        end else begin
                            r_pos <= r_pos + PBW'(1);
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign w_acc_ctl.valid = r_rd_valid;
    assign w_acc_ctl.first = r_rd_first;
    assign w_acc_ctl.last  = r_rd_last;

    ssmh_acc #(
        .SAMPLE_BITS  (SAMPLE_BITS),
        .HISTORY_DEPTH(HISTORY_DEPTH),
        .AW           (AW)
    ) u_acc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_acc_ctl),
        .i_src_re(w_rd_sre),
        .i_src_im(w_rd_sim),
        .i_res_re(w_rd_rre),
        .i_res_im(w_rd_rim),
        .i_weight(w_weight[r_rd_age]),
        .o_ssum  (w_ssum),
        .o_tsum  (w_tsum),
        .o_done  (w_acc_done)
    );

    assign w_div_start = (r_state == ST_ACC) & w_acc_done;

    ssmh_div #(
        .AW(AW)
    ) u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(w_div_start),
        .i_ssum (w_ssum),
        .i_tsum (w_tsum),
        .o_mask (w_q),
        .o_done (w_div_done)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_mask <= r_enable ? r_mask : '0;
            r_out_user <= r_enable;
            r_out_last <= r_ends;
            r_out_cmre <= r_cmix_re;
            r_out_cmim <= r_cmix_im;
            r_out_csre <= r_csrc_re;
            r_out_csim <= r_csrc_im;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_user;
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tdata  = OUT_TW'({r_out_csim, r_out_csre, r_out_cmim, r_out_cmre,
                                    r_out_mask});

endmodule

FILE: rtl/core/ssmh_acc.sv
// weighted power accumulation pipeline: square, sum, weight, accumulate
module ssmh_acc
    import ssmh_pkg::*;
#(
    parameter int SAMPLE_BITS = 24,
    parameter int HISTORY_DEPTH = 8,
    parameter int AW = 2 * (SAMPLE_BITS + 1) + 1 + 17 + 4
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_acc_ctl                  i_ctl,
    input  logic signed [SAMPLE_BITS-1:0] i_src_re,
    input  logic signed [SAMPLE_BITS-1:0] i_src_im,
    input  logic signed [SAMPLE_BITS:0]   i_res_re,
    input  logic signed [SAMPLE_BITS:0]   i_res_im,
    input  logic [WeightW-1:0]        i_weight,
    output logic [AW-1:0]             o_ssum,
    output logic [AW-1:0]             o_tsum,
    output logic                      o_done
);

    localparam int RW = SAMPLE_BITS + 1;
    localparam int SQW = 2 * RW;
    localparam int PW = SQW + 1;
    localparam int HB = (PW + 1) / 2;
    localparam int HI = PW - HB;
    localparam int TW = PW + WeightW;

    logic signed [RW-1:0]  w_sre;
    logic signed [RW-1:0]  w_sim;
    logic signed [SQW-1:0] w_sq0;
    logic signed [SQW-1:0] w_sq1;
    logic signed [SQW-1:0] w_sq2;
    logic signed [SQW-1:0] w_sq3;

    t_acc_ctl             r1_ctl, r2_ctl, r3_ctl;
    logic [SQW-1:0]       r1_sq0, r1_sq1, r1_sq2, r1_sq3;
    logic [WeightW-1:0]   r1_w, r2_w;
    logic [PW-1:0]        r2_ps, r2_pr;
    logic [HB+WeightW-1:0] r3_slo, r3_rlo;
    logic [HI+WeightW-1:0] r3_shi, r3_rhi;
    logic [TW-1:0]        w_sterm, w_rterm;
    logic [AW-1:0]        r_ssum, r_tsum, n_ssum, n_tsum;
    logic                 r_done;

    assign w_sre = RW'(i_src_re);
    assign w_sim = RW'(i_src_im);
    assign w_sq0 = w_sre * w_sre;
    assign w_sq1 = w_sim * w_sim;
    assign w_sq2 = i_res_re * i_res_re;
    assign w_sq3 = i_res_im * i_res_im;

    always_ff @(posedge i_clk) begin
        r1_sq0 <= w_sq0;
        r1_sq1 <= w_sq1;
        r1_sq2 <= w_sq2;
        r1_sq3 <= w_sq3;
        r1_w   <= i_weight;
        r2_ps  <= PW'(r1_sq0) + PW'(r1_sq1);
        r2_pr  <= PW'(r1_sq2) + PW'(r1_sq3);
        r2_w   <= r1_w;
        r3_slo <= (HB+WeightW)'(r2_ps[HB-1:0]) * (HB+WeightW)'(r2_w);
        r3_shi <= (HI+WeightW)'(r2_ps[PW-1:HB]) * (HI+WeightW)'(r2_w);
        r3_rlo <= (HB+WeightW)'(r2_pr[HB-1:0]) * (HB+WeightW)'(r2_w);
        r3_rhi <= (HI+WeightW)'(r2_pr[PW-1:HB]) * (HI+WeightW)'(r2_w);
    end

    assign w_sterm = TW'(r3_slo) + (TW'(r3_shi) << HB);
    assign w_rterm = TW'(r3_rlo) + (TW'(r3_rhi) << HB);

    always_comb begin
        if (r3_ctl.first) begin
            n_ssum = AW'(w_sterm);
            n_tsum = AW'(w_sterm) + AW'(w_rterm);
        end else begin
            n_ssum = r_ssum + AW'(w_sterm);
            n_tsum = r_tsum + AW'(w_sterm) + AW'(w_rterm);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r3_ctl.valid) begin
            r_ssum <= n_ssum;
            r_tsum <= n_tsum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_ctl <= '0;
            r2_ctl <= '0;
            r3_ctl <= '0;
            r_done <= 1'b0;
        end else begin
            r1_ctl <= i_ctl;
            r2_ctl <= r1_ctl;
            r3_ctl <= r2_ctl;
            r_done <= r3_ctl.valid & r3_ctl.last;
        end
    end

    assign o_ssum = r_ssum;
    assign o_tsum = r_tsum;
    assign o_done = r_done;

endmodule

FILE: rtl/core/ssmh_div.sv
// restoring divider for the mask ratio, one quotient bit per cycle
module ssmh_div
    import ssmh_pkg::*;
#(
    parameter int AW = 72
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [AW-1:0]    i_ssum,
    input  logic [AW-1:0]    i_tsum,
    output logic [MaskW-1:0] o_mask,
    output logic             o_done
);

    localparam int NW = AW + MaskW;

    logic [NW-1:0]    r_num, r_den;
    logic [MaskW-1:0] r_q;
    logic [3:0]       r_cnt;
    logic             r_busy, r_zero, r_done;
    logic             w_ge;

    assign w_ge = (r_num >= r_den);

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num  <= (NW'(i_ssum) << MaskW) - NW'(i_ssum);
            r_den  <= NW'(i_tsum) << (MaskW - 1);
            r_zero <= (i_tsum == '0);
            r_q    <= '0;
        end else if (r_busy) begin
            if (w_ge) begin
                r_num <= r_num - r_den;
            end
            r_q   <= {r_q[MaskW-2:0], w_ge};
            r_den <= r_den >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 4'd1;
                if (r_cnt == 4'(MaskW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_mask = r_zero ? '0 : r_q;
    assign o_done = r_done;

endmodule
